FILE: sv/lpsc_pkg.sv
package lpsc_pkg;

    // configuration register indexes
    typedef logic [2:0] t_cfg_index;
    localparam t_cfg_index CFG_REF_X      = 3'd0;
    localparam t_cfg_index CFG_REF_Y      = 3'd1;
    localparam t_cfg_index CFG_REF_SLOPE  = 3'd2;
    localparam t_cfg_index CFG_BORDER_ROW = 3'd3;
    localparam t_cfg_index CFG_MIN_POINTS = 3'd4;

    // sector codes
    typedef logic [2:0] t_sector;
    localparam t_sector SEC_TOP_LEFT     = 3'd0;
    localparam t_sector SEC_BOTTOM_LEFT  = 3'd1;
    localparam t_sector SEC_TOP_RIGHT    = 3'd2;
    localparam t_sector SEC_BOTTOM_RIGHT = 3'd3;
    localparam t_sector SEC_ON_LINE      = 3'd4;
    localparam t_sector SEC_UNCLASSIFIED = 3'd5;

    // field widths
    localparam int COORD_W     = 10;
    localparam int REF_SLOPE_W = 19;
    localparam int MIN_PTS_W   = 12;
    localparam int OUT_SLOPE_W = 18;
    localparam int CFG_DATA_W  = 19;

    // reset values of the registers
    localparam logic [COORD_W-1:0]     RST_REF_X      = 10'd320;
    localparam logic [COORD_W-1:0]     RST_REF_Y      = 10'd300;
    localparam logic [REF_SLOPE_W-1:0] RST_REF_SLOPE  = 19'd255744;
    localparam logic [COORD_W-1:0]     RST_BORDER_ROW = 10'd140;
    localparam logic [MIN_PTS_W-1:0]   RST_MIN_POINTS = 12'd3;

    // segment slope clamp, in whole units
    localparam int SLOPE_LIMIT = 500;

endpackage

FILE: sv/lane_point_sector_classifier.sv
// Lane point sector classifier. Each input item may carry one line segment and may close a
// frame. For a segment the block emits two result items, start point then end point, each
// with its sector code and the segment slope dy/dx (truncated, clamped to +-500, with
// SLOPE_FRAC_BITS fraction bits); an item with frame_end set is followed by one summary
// item with the four sector presence flags, after which the sector counts are cleared.
// o_last marks the final result of an input item; an item with neither flag gives none.
// Work is done one item at a time by a small sequencer around one shared restoring divider
// and one shared multiplier, so o_ready is high only while the block is idle. The divider
// runs once per segment item for the row-0 crossing of the reference line (skipped when
// the reference slope is zero) and once for the segment slope (skipped when dx is zero),
// one quotient bit per cycle. Configuration writes are always accepted and should only be
// made while the block is idle. There is no clearing pass after reset.
module lane_point_sector_classifier
    import lpsc_pkg::*;
#(
    parameter int SLOPE_FRAC_BITS = 8,
    parameter int COUNT_WIDTH     = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [2:0]                    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    // input items
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [COORD_W-1:0]            i_start_x,
    input  logic [COORD_W-1:0]            i_start_y,
    input  logic [COORD_W-1:0]            i_end_x,
    input  logic [COORD_W-1:0]            i_end_y,
    input  logic                          i_segment_valid,
    input  logic                          i_frame_end,
    // result items
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [COORD_W-1:0]            o_point_x,
    output logic [COORD_W-1:0]            o_point_y,
    output logic [2:0]                    o_sector_code,
    output logic signed [OUT_SLOPE_W-1:0] o_segment_slope,
    output logic                          o_is_summary,
    output logic [3:0]                    o_sector_flags,
    output logic                          o_last
);

    localparam int F = SLOPE_FRAC_BITS;
    // magnitude width of the larger dividend: |ref_x*ref_slope - ref_y*2^F|
    localparam int NW   = ((28 > COORD_W + F) ? 28 : COORD_W + F) + 1;
    localparam int DVW  = REF_SLOPE_W;              // divisor magnitude width
    localparam int CNTW = $clog2(NW + 1);
    localparam int OPAW = NW + 2;                   // ref_x - bx and friends
    localparam int PW   = OPAW + REF_SLOPE_W;       // product width
    localparam int SW   = COORD_W + F + 1;          // internal slope width
    localparam int SWX  = (SW > OUT_SLOPE_W) ? SW : OUT_SLOPE_W;
    localparam int CMPW = (COUNT_WIDTH > MIN_PTS_W) ? COUNT_WIDTH : MIN_PTS_W;
    localparam logic [NW-1:0]          LIM      = NW'(SLOPE_LIMIT) << F;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = '1;
    localparam logic [CNTW-1:0]        ITER_BX  = CNTW'(NW);
    localparam logic [CNTW-1:0]        ITER_SL  = CNTW'(COORD_W + F);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_RS,
        S_BX_LOAD,
        S_BX_DIV,
        S_SL_LOAD,
        S_SL_DIV,
        S_MUL_A,
        S_MUL_B,
        S_CLASS,
        S_SUM,
        S_OUT
    } t_state;

    // ---------------------------------------------------------------------------------
    // configuration registers; always ready
    // ---------------------------------------------------------------------------------
    logic [COORD_W-1:0]            r_ref_x;
    logic [COORD_W-1:0]            r_ref_y;
    logic signed [REF_SLOPE_W-1:0] r_ref_slope;
    logic [COORD_W-1:0]            r_border_row;
    logic [MIN_PTS_W-1:0]          r_min_points;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_x      <= RST_REF_X;
            r_ref_y      <= RST_REF_Y;
            r_ref_slope  <= RST_REF_SLOPE;
            r_border_row <= RST_BORDER_ROW;
            r_min_points <= RST_MIN_POINTS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_REF_X:      r_ref_x      <= i_cfg_data[COORD_W-1:0];
                CFG_REF_Y:      r_ref_y      <= i_cfg_data[COORD_W-1:0];
                CFG_REF_SLOPE:  r_ref_slope  <= i_cfg_data[REF_SLOPE_W-1:0];
                CFG_BORDER_ROW: r_border_row <= i_cfg_data[COORD_W-1:0];
                CFG_MIN_POINTS: r_min_points <= i_cfg_data[MIN_PTS_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------------------
    // datapath registers
    // ---------------------------------------------------------------------------------
    t_state                      r_state;
    logic [COORD_W-1:0]          r_sx, r_sy, r_ex, r_ey;
    logic                        r_frame_end;
    logic                        r_pt;          // 0 start point, 1 end point
    logic signed [PW-1:0]        r_prod;
    logic signed [PW-1:0]        r_prod2;
    logic signed [NW:0]          r_bx;
    logic signed [SW-1:0]        r_slope;
    // divider
    logic [NW-1:0]               r_num;         // dividend shifts out, quotient shifts in
    logic [DVW-1:0]              r_rem;
    logic [DVW-1:0]              r_den;
    logic [CNTW-1:0]             r_iter;
    logic                        r_qneg;
    // sector counts
    logic [COUNT_WIDTH-1:0]      r_cnt_tl, r_cnt_tr, r_cnt_bl, r_cnt_br;
    // result register
    logic [COORD_W-1:0]          r_o_x, r_o_y;
    t_sector                     r_o_code;
    logic [OUT_SLOPE_W-1:0]      r_o_slope;
    logic                        r_o_summary;
    logic [3:0]                  r_o_flags;
    logic                        r_o_last;

    // current endpoint
    logic [COORD_W-1:0] pt_x, pt_y;
    assign pt_x = r_pt ? r_ex : r_sx;
    assign pt_y = r_pt ? r_ey : r_sy;

    // ---------------------------------------------------------------------------------
    // shared multiplier: ref_x*slope, (ref_x-bx)*y, ref_y*(x-bx)
    // ---------------------------------------------------------------------------------
    logic signed [OPAW-1:0]        op_a;
    logic signed [REF_SLOPE_W-1:0] op_b;
    logic signed [PW-1:0]          mul_p;

    always_comb begin
        case (r_state)
            S_MUL_A: begin
                op_a = OPAW'(r_ref_x) - OPAW'(r_bx);
                op_b = REF_SLOPE_W'(pt_y);
            end
            S_MUL_B: begin
                op_a = OPAW'(pt_x) - OPAW'(r_bx);
                op_b = REF_SLOPE_W'(r_ref_y);
            end
            default: begin
                op_a = OPAW'(r_ref_x);
                op_b = r_ref_slope;
            end
        endcase
    end

    assign mul_p = op_a * op_b;

    // ---------------------------------------------------------------------------------
    // divider step, one quotient bit per cycle
    // ---------------------------------------------------------------------------------
    logic [DVW:0]   rem_sh, rem_sub;
    logic           q_bit;
    logic [DVW-1:0] rem_nx;

    assign rem_sh  = {r_rem, r_num[NW-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign q_bit   = !rem_sub[DVW];
    assign rem_nx  = q_bit ? rem_sub[DVW-1:0] : rem_sh[DVW-1:0];

    // row-0 crossing dividend and divisor magnitudes
    logic signed [PW-1:0]    ay_sh, bx_num;
    logic [PW-1:0]           bx_mag;
    logic [REF_SLOPE_W-1:0]  rs_mag;

    assign ay_sh  = PW'(r_ref_y) << F;
    assign bx_num = r_prod - ay_sh;
    assign bx_mag = bx_num[PW-1] ? PW'(-bx_num) : PW'(bx_num);
    assign rs_mag = r_ref_slope[REF_SLOPE_W-1] ? REF_SLOPE_W'(-r_ref_slope)
                                               : REF_SLOPE_W'(r_ref_slope);

    // segment deltas
    logic signed [COORD_W:0] dx, dy;
    logic [COORD_W-1:0]      dx_mag, dy_mag;

    assign dx     = (COORD_W + 1)'(r_ex) - (COORD_W + 1)'(r_sx);
    assign dy     = (COORD_W + 1)'(r_ey) - (COORD_W + 1)'(r_sy);
    assign dx_mag = dx[COORD_W] ? COORD_W'(-dx) : COORD_W'(dx);
    assign dy_mag = dy[COORD_W] ? COORD_W'(-dy) : COORD_W'(dy);

    // quotient finishing
    logic [NW:0]    q_ext;
    logic [NW-1:0]  sl_mag;
    logic [SW-1:0]  sl_ext;

    assign q_ext  = {1'b0, r_num};
    assign sl_mag = (r_num > LIM) ? LIM : r_num;
    assign sl_ext = SW'(sl_mag);

    // slope as shown on the port
    logic signed [SWX-1:0] slope_x;
    assign slope_x = SWX'(r_slope);

    // classification of the current endpoint
    logic signed [PW-1:0] alfa;
    logic                 alfa_pos, alfa_neg;
    logic                 y_above, y_below;
    t_sector              code;

    assign alfa     = r_prod2 - r_prod;
    assign alfa_neg = alfa[PW-1];
    assign alfa_pos = !alfa[PW-1] && (alfa != '0);
    assign y_above  = pt_y < r_border_row;
    assign y_below  = pt_y > r_border_row;

    always_comb begin
        if (alfa_pos && y_above)      code = SEC_TOP_LEFT;
        else if (alfa_pos && y_below) code = SEC_BOTTOM_LEFT;
        else if (alfa_neg && y_above) code = SEC_TOP_RIGHT;
        else if (alfa_neg && y_below) code = SEC_BOTTOM_RIGHT;
        else if (!alfa_pos && !alfa_neg) code = SEC_ON_LINE;
        else                          code = SEC_UNCLASSIFIED;
    end

    // summary flags
    logic [3:0] flags;
    assign flags = {CMPW'(r_cnt_tl) > CMPW'(r_min_points),
                    CMPW'(r_cnt_tr) > CMPW'(r_min_points),
                    CMPW'(r_cnt_bl) > CMPW'(r_min_points),
                    CMPW'(r_cnt_br) > CMPW'(r_min_points)};

    // ---------------------------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pt     <= 1'b0;
            r_cnt_tl <= '0;
            r_cnt_tr <= '0;
            r_cnt_bl <= '0;
            r_cnt_br <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_sx        <= i_start_x;
                        r_sy        <= i_start_y;
                        r_ex        <= i_end_x;
                        r_ey        <= i_end_y;
                        r_frame_end <= i_frame_end;
                        r_pt        <= 1'b0;
                        if (i_segment_valid) r_state <= S_MUL_RS;
                        else if (i_frame_end) r_state <= S_SUM;
                    end
                end
                S_MUL_RS: begin
                    r_prod  <= mul_p;
                    r_state <= S_BX_LOAD;
                end
                S_BX_LOAD: begin
                    if (r_ref_slope == '0) begin
                        // flat reference line: crossing taken as ref_x
                        r_bx    <= (NW + 1)'(r_ref_x);
                        r_state <= S_SL_LOAD;
                    end else begin
                        r_num   <= bx_mag[NW-1:0];
                        r_rem   <= '0;
                        r_den   <= rs_mag;
                        r_qneg  <= bx_num[PW-1] ^ r_ref_slope[REF_SLOPE_W-1];
                        r_iter  <= ITER_BX;
                        r_state <= S_BX_DIV;
                    end
                end
                S_BX_DIV: begin
                    if (r_iter == '0) begin
                        r_bx    <= r_qneg ? -q_ext : q_ext;
                        r_state <= S_SL_LOAD;
                    end else begin
                        r_num  <= {r_num[NW-2:0], q_bit};
                        r_rem  <= rem_nx;
                        r_iter <= r_iter - 1'b1;
                    end
                end
                S_SL_LOAD: begin
                    if (dx == '0) begin
                        // vertical or zero-length segment
                        if (dy == '0)         r_slope <= '0;
                        else if (dy[COORD_W]) r_slope <= -SW'(LIM);
                        else                  r_slope <= SW'(LIM);
                        r_state <= S_MUL_A;
                    end else begin
                        // |dy|<<F, left-aligned in the dividend
                        r_num   <= NW'(dy_mag) << (NW - COORD_W);
                        r_rem   <= '0;
                        r_den   <= DVW'(dx_mag);
                        r_qneg  <= dx[COORD_W] ^ dy[COORD_W];
                        r_iter  <= ITER_SL;
                        r_state <= S_SL_DIV;
                    end
                end
                S_SL_DIV: begin
                    if (r_iter == '0) begin
                        r_slope <= r_qneg ? -sl_ext : sl_ext;
                        r_state <= S_MUL_A;
                    end else begin
                        r_num  <= {r_num[NW-2:0], q_bit};
                        r_rem  <= rem_nx;
                        r_iter <= r_iter - 1'b1;
                    end
                end
                S_MUL_A: begin
                    r_prod2 <= mul_p;
                    r_state <= S_MUL_B;
                end
                S_MUL_B: begin
                    r_prod  <= mul_p;
                    r_state <= S_CLASS;
                end
                S_CLASS: begin
                    case (code)
                        SEC_TOP_LEFT:     if (r_cnt_tl != CNT_MAX) r_cnt_tl <= r_cnt_tl + 1'b1;
                        SEC_BOTTOM_LEFT:  if (r_cnt_bl != CNT_MAX) r_cnt_bl <= r_cnt_bl + 1'b1;
                        SEC_TOP_RIGHT:    if (r_cnt_tr != CNT_MAX) r_cnt_tr <= r_cnt_tr + 1'b1;
                        SEC_BOTTOM_RIGHT: if (r_cnt_br != CNT_MAX) r_cnt_br <= r_cnt_br + 1'b1;
                        default: ;
                    endcase
                    r_o_x       <= pt_x;
                    r_o_y       <= pt_y;
                    r_o_code    <= code;
                    r_o_slope   <= slope_x[OUT_SLOPE_W-1:0];
                    r_o_summary <= 1'b0;
                    r_o_flags   <= '0;
                    r_o_last    <= r_pt && !r_frame_end;
                    r_state     <= S_OUT;
                end
                S_SUM: begin
                    r_o_x       <= '0;
                    r_o_y       <= '0;
                    r_o_code    <= SEC_TOP_LEFT;
                    r_o_slope   <= '0;
                    r_o_summary <= 1'b1;
                    r_o_flags   <= flags;
                    r_o_last    <= 1'b1;
                    r_cnt_tl    <= '0;
                    r_cnt_tr    <= '0;
                    r_cnt_bl    <= '0;
                    r_cnt_br    <= '0;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        if (r_o_summary) begin
                            r_state <= S_IDLE;
                        end else if (!r_pt) begin
                            r_pt    <= 1'b1;
                            r_state <= S_MUL_A;
                        end else if (r_frame_end) begin
                            r_state <= S_SUM;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = (r_state == S_OUT);
    assign o_point_x       = r_o_x;
    assign o_point_y       = r_o_y;
    assign o_sector_code   = r_o_code;
    assign o_segment_slope = r_o_slope;
    assign o_is_summary    = r_o_summary;
    assign o_sector_flags  = r_o_flags;
    assign o_last          = r_o_last;

    // ---------------------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------------------
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("input taken while a result is pending");

    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_summary) |-> (o_last && o_point_x == '0 && o_point_y == '0
                                       && o_segment_slope == '0))
        else $error("summary item malformed");

    a_point_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_summary) |-> (o_sector_flags == '0))
        else $error("endpoint item carries flags");

    a_counts_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_is_summary) |=>
            (r_cnt_tl == '0 && r_cnt_tr == '0 && r_cnt_bl == '0 && r_cnt_br == '0))
        else $error("sector counts not cleared after summary");

    a_first_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_summary && !r_pt) |-> !o_last)
        else $error("start point marked last");

endmodule

FILE: tb/tb_lane_point_sector_classifier.sv
`timescale 1ns / 1ps

module tb_lane_point_sector_classifier;
    import lpsc_pkg::*;

    // Block configuration, kept at the block's defaults
    localparam int FRAC_BITS = 8;
    localparam int COUNT_W   = 12;

    // Run control
    localparam int LIMIT_CYCLES  = 1_000_000;  // watchdog, several times the slowest run
    localparam int SETTLE_CYCLES = 100;        // longer than one item's worst latency
    localparam int HOLD_CYCLES   = 400;        // long receiver hold-off
    localparam int FILL_SEGMENTS = 20;         // 40 top-left points

    // One result item as seen on the output port
    typedef struct {
        logic [COORD_W-1:0]            px;
        logic [COORD_W-1:0]            py;
        t_sector                       code;
        logic signed [OUT_SLOPE_W-1:0] slope;
        logic                          summ;
        logic [3:0]                    flags;
        logic                          last;
    } t_point_result;

    // Sector scoreboard: mirrors the configuration and the four sector counts,
    // turns each accepted item into the result items it should cause, and
    // checks the outgoing items against them in order.
    class sector_scoreboard;
        logic [COORD_W-1:0]            ref_x, ref_y, border_row;
        logic signed [REF_SLOPE_W-1:0] ref_slope;
        logic [MIN_PTS_W-1:0]          min_points;
        logic [COUNT_W-1:0]            cnt_tl, cnt_tr, cnt_bl, cnt_br;
        t_point_result                 awaited_q[$];
        int                            n_mismatch;
        int                            n_errors;

        function new();
            ref_x      = RST_REF_X;
            ref_y      = RST_REF_Y;
            ref_slope  = RST_REF_SLOPE;
            border_row = RST_BORDER_ROW;
            min_points = RST_MIN_POINTS;
            cnt_tl = '0; cnt_tr = '0; cnt_bl = '0; cnt_br = '0;
            n_mismatch = 0;
            n_errors   = 0;
        endfunction

        function void write_reg(t_cfg_index idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_REF_X:      ref_x      = data[COORD_W-1:0];
                CFG_REF_Y:      ref_y      = data[COORD_W-1:0];
                CFG_REF_SLOPE:  ref_slope  = data[REF_SLOPE_W-1:0];
                CFG_BORDER_ROW: border_row = data[COORD_W-1:0];
                CFG_MIN_POINTS: min_points = data[MIN_PTS_W-1:0];
                default: ;
            endcase
        endfunction

        // column where the reference line meets row 0, truncated toward zero
        function longint crossing_col();
            longint ax, ay, rs;
            ax = longint'(ref_x);
            ay = longint'(ref_y);
            rs = longint'(ref_slope);
            if (rs == 0) return ax;
            return (ax * rs - ay * (longint'(1) <<< FRAC_BITS)) / rs;
        endfunction

        function logic [COUNT_W-1:0] bumped(logic [COUNT_W-1:0] c);
            return (c == '1) ? c : c + 1'b1;
        endfunction

        // sector of one endpoint; updates the counts as a side effect
        function t_sector sort_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
            longint ax, ay, bx, alfa, yy, br;
            ax   = longint'(ref_x);
            ay   = longint'(ref_y);
            bx   = crossing_col();
            yy   = longint'(y);
            br   = longint'(border_row);
            alfa = (ax - bx) * yy - ay * (longint'(x) - bx);
            if (alfa > 0 && yy < br) begin
                cnt_tl = bumped(cnt_tl);
                return SEC_TOP_LEFT;
            end
            if (alfa > 0 && yy > br) begin
                cnt_bl = bumped(cnt_bl);
                return SEC_BOTTOM_LEFT;
            end
            if (alfa < 0 && yy < br) begin
                cnt_tr = bumped(cnt_tr);
                return SEC_TOP_RIGHT;
            end
            if (alfa < 0 && yy > br) begin
                cnt_br = bumped(cnt_br);
                return SEC_BOTTOM_RIGHT;
            end
            if (alfa == 0) return SEC_ON_LINE;
            return SEC_UNCLASSIFIED;
        endfunction

        function logic signed [OUT_SLOPE_W-1:0] slope_of(
            logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
            logic [COORD_W-1:0] ex, logic [COORD_W-1:0] ey);
            longint dx, dy, lim, q;
            dx  = longint'(ex) - longint'(sx);
            dy  = longint'(ey) - longint'(sy);
            lim = longint'(SLOPE_LIMIT) <<< FRAC_BITS;
            if (dx == 0) begin
                q = (dy > 0) ? lim : ((dy < 0) ? -lim : 0);
            end else begin
                q = (dy * (longint'(1) <<< FRAC_BITS)) / dx;
                if (q > lim)  q = lim;
                if (q < -lim) q = -lim;
            end
            return q[OUT_SLOPE_W-1:0];
        endfunction

        // append one awaited result item
        function void queue_result(t_point_result r);
            awaited_q.insert(awaited_q.size(), r);
        endfunction

        // an input item was accepted: queue the result items it causes
        function void note_item(logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
                                logic [COORD_W-1:0] ex, logic [COORD_W-1:0] ey,
                                logic seg, logic fe);
            t_point_result r;
            int            first;
            first = awaited_q.size();
            if (seg) begin
                r.slope = slope_of(sx, sy, ex, ey);
                r.summ  = 1'b0;
                r.flags = 4'd0;
                r.last  = 1'b0;
                r.px    = sx;
                r.py    = sy;
                r.code  = sort_point(sx, sy);
                queue_result(r);
                r.px    = ex;
                r.py    = ey;
                r.code  = sort_point(ex, ey);
                queue_result(r);
            end
            if (fe) begin
                r.px    = '0;
                r.py    = '0;
                r.code  = SEC_TOP_LEFT;
                r.slope = '0;
                r.summ  = 1'b1;
                r.flags = {cnt_tl > min_points, cnt_tr > min_points,
                           cnt_bl > min_points, cnt_br > min_points};
                r.last  = 1'b0;
                queue_result(r);
                cnt_tl = '0; cnt_tr = '0; cnt_bl = '0; cnt_br = '0;
            end
            if (awaited_q.size() > first)
                awaited_q[awaited_q.size() - 1].last = 1'b1;
        endfunction

        function int pending();
            return awaited_q.size();
        endfunction

        function string fmt_item(t_point_result r);
            return {$sformatf("x=%0d y=%0d code=%0d slope=%0d", r.px, r.py, r.code, r.slope),
                    $sformatf(" summ=%0d flags=%h last=%0d", r.summ, r.flags, r.last)};
        endfunction

        function void check_result(t_point_result got);
            t_point_result want;
            if (awaited_q.size() == 0) begin
                n_errors++;
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result item: %s", fmt_item(got));
                return;
            end
            want = awaited_q.pop_front();
            if (got.px !== want.px || got.py !== want.py || got.code !== want.code ||
                got.slope !== want.slope || got.summ !== want.summ ||
                got.flags !== want.flags || got.last !== want.last) begin
                n_errors++;
                n_mismatch++;
                if (n_mismatch <= 10) begin
                    $display("result mismatch, expected: %s", fmt_item(want));
                    $display("                actual:   %s", fmt_item(got));
                end
            end
        endfunction
    endclass

    // DUT ports
    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [2:0]                    i_cfg_index;
    logic [CFG_DATA_W-1:0]         i_cfg_data;
    logic                          i_valid;
    logic                          o_ready;
    logic [COORD_W-1:0]            i_start_x;
    logic [COORD_W-1:0]            i_start_y;
    logic [COORD_W-1:0]            i_end_x;
    logic [COORD_W-1:0]            i_end_y;
    logic                          i_segment_valid;
    logic                          i_frame_end;
    logic                          o_valid;
    logic                          i_ready;
    logic [COORD_W-1:0]            o_point_x;
    logic [COORD_W-1:0]            o_point_y;
    logic [2:0]                    o_sector_code;
    logic signed [OUT_SLOPE_W-1:0] o_segment_slope;
    logic                          o_is_summary;
    logic [3:0]                    o_sector_flags;
    logic                          o_last;

    // Flags set by the stimulus, some read by the sink; cycle_count counts clocks
    bit tx_idle_on  = 1'b1;
    bit rx_idle_on  = 1'b1;
    int hold_serial = 0;
    int cycle_count = 0;

    sector_scoreboard sb = new();

    lane_point_sector_classifier #(
        .SLOPE_FRAC_BITS(FRAC_BITS),
        .COUNT_WIDTH    (COUNT_W)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_end_x        (i_end_x),
        .i_end_y        (i_end_y),
        .i_segment_valid(i_segment_valid),
        .i_frame_end    (i_frame_end),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_point_x      (o_point_x),
        .o_point_y      (o_point_y),
        .o_sector_code  (o_sector_code),
        .o_segment_slope(o_segment_slope),
        .o_is_summary   (o_is_summary),
        .o_sector_flags (o_sector_flags),
        .o_last         (o_last)
    );

    // 10 ns clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: a hung handshake or a lost result item ends the run here
    initial begin : watchdog
        while (cycle_count < LIMIT_CYCLES) @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

    // Result sink. Outputs are sampled right after the edge, so they still
    // hold the values that took part in that edge's handshake. Ready idles
    // in random bursts, and drops for a long stretch whenever the stimulus
    // asks for a hold-off, so that the block backs up and stalls its input.
    initial begin : result_sink
        int            stall_left;
        int            hold_left;
        int            hold_served;
        t_point_result got;
        stall_left  = 0;
        hold_left   = 0;
        hold_served = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                got.px    = o_point_x;
                got.py    = o_point_y;
                got.code  = o_sector_code;
                got.slope = o_segment_slope;
                got.summ  = o_is_summary;
                got.flags = o_sector_flags;
                got.last  = o_last;
                sb.check_result(got);
            end
            if (hold_serial != hold_served) begin
                hold_served = hold_serial;
                hold_left   = HOLD_CYCLES;
            end
            if (!i_rst_n) begin
                i_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 14) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // One input item. Valid stays high from one item to the next unless an
    // idle burst comes between them; the item is noted on the accepting edge.
    task automatic send_item(logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
                             logic [COORD_W-1:0] ex, logic [COORD_W-1:0] ey,
                             logic seg, logic fe);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_start_x       <= sx;
        i_start_y       <= sy;
        i_end_x         <= ex;
        i_end_y         <= ey;
        i_segment_valid <= seg;
        i_frame_end     <= fe;
        do @(posedge i_clk); while (!o_ready);
        sb.note_item(sx, sy, ex, ey, seg, fe);
    endtask

    // Random item: mostly segments, with frame closes, bare summaries, empty
    // items and the corner cases (vertical, zero length, border row, points
    // on the reference line, steep enough to clamp) mixed in.
    task automatic send_random_item();
        logic [COORD_W-1:0] sx, sy, ex, ey;
        logic               seg, fe;
        int                 pick;
        longint             bx;
        sx   = COORD_W'($urandom_range(0, 1023));
        sy   = COORD_W'($urandom_range(0, 1023));
        ex   = COORD_W'($urandom_range(0, 1023));
        ey   = COORD_W'($urandom_range(0, 1023));
        pick = $urandom_range(0, 99);
        seg  = (pick >= 12);
        fe   = (pick < 8) || (pick >= 12 && $urandom_range(0, 7) == 0);
        case ($urandom_range(0, 12))
            0: ex = sx;
            1: begin
                ex = sx;
                ey = sy;
            end
            2: sy = sb.border_row;
            3: ey = sb.border_row;
            4: begin
                sx = sb.ref_x;
                sy = sb.ref_y;
            end
            5: ex = (sx == 10'd1023) ? sx - 1'b1 : sx + 1'b1;
            6: begin
                bx = sb.crossing_col();
                if (bx >= 0 && bx <= 1023) begin
                    ex = bx[COORD_W-1:0];
                    ey = '0;
                end
            end
            default: ;
        endcase
        send_item(sx, sy, ex, ey, seg, fe);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
    endtask

    // all five registers back to back; valid drops only after the last one
    task automatic set_config(logic [COORD_W-1:0] rx, logic [COORD_W-1:0] ry,
                              logic [REF_SLOPE_W-1:0] rs, logic [COORD_W-1:0] br,
                              logic [MIN_PTS_W-1:0] mp);
        write_reg(CFG_REF_X, CFG_DATA_W'(rx));
        write_reg(CFG_REF_Y, CFG_DATA_W'(ry));
        write_reg(CFG_REF_SLOPE, CFG_DATA_W'(rs));
        write_reg(CFG_BORDER_ROW, CFG_DATA_W'(br));
        write_reg(CFG_MIN_POINTS, CFG_DATA_W'(mp));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_random_config();
        int v;
        int mp;
        case ($urandom_range(0, 4))
            0:       v = int'($urandom_range(0, 512000)) - 256000;
            1:       v = int'($urandom_range(0, 1024)) - 512;
            2:       v = 0;
            default: v = int'($urandom_range(0, 20000)) - 10000;
        endcase
        mp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 8);
        set_config(COORD_W'($urandom_range(0, 1023)), COORD_W'($urandom_range(0, 1023)),
                   REF_SLOPE_W'(v), COORD_W'($urandom_range(0, 1023)), MIN_PTS_W'(mp));
    endtask

    // stop offering, let every awaited result item arrive, then let an item
    // with no results finish too, so the block is idle for a register write
    task automatic drain_and_settle();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        i_rst_n         <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= CFG_REF_X;
        i_cfg_data      <= '0;
        i_valid         <= 1'b0;
        i_start_x       <= '0;
        i_start_y       <= '0;
        i_end_x         <= '0;
        i_end_y         <= '0;
        i_segment_valid <= 1'b0;
        i_frame_end     <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items under the reset configuration. The reference line
        // meets row 0 at column 319 and passes through (320,300).
        send_item(10'd0, 10'd0, 10'd1023, 10'd1023, 1'b1, 1'b0);
        send_item(10'd1023, 10'd1023, 10'd0, 10'd0, 1'b1, 1'b0);
        send_item(10'd5, 10'd10, 10'd5, 10'd900, 1'b1, 1'b0);     // vertical, rising
        send_item(10'd5, 10'd900, 10'd5, 10'd10, 1'b1, 1'b0);     // vertical, falling
        send_item(10'd400, 10'd400, 10'd400, 10'd400, 1'b1, 1'b0); // zero length
        send_item(10'd100, 10'd0, 10'd101, 10'd1023, 1'b1, 1'b0);  // clamps high
        send_item(10'd100, 10'd1023, 10'd101, 10'd0, 1'b1, 1'b0);  // clamps low
        send_item(10'd10, 10'd20, 10'd13, 10'd19, 1'b1, 1'b0);     // negative, truncated
        send_item(10'd319, 10'd0, 10'd320, 10'd300, 1'b1, 1'b0);   // both on the line
        send_item(10'd0, 10'd140, 10'd1023, 10'd140, 1'b1, 1'b0);  // both on border row
        send_item(10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b1);         // summary only
        send_item(10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b0, 1'b0); // no results
        send_item(10'd200, 10'd50, 10'd600, 10'd700, 1'b1, 1'b1);
        send_item(10'd0, 10'd1023, 10'd1023, 10'd0, 1'b1, 1'b1);
        // fill top-left and bottom-right past the minimum, then the other two
        repeat (4) send_item(10'd100, 10'd50, 10'd900, 10'd900, 1'b1, 1'b0);
        send_item(10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b1);
        repeat (3) send_item(10'd600, 10'd50, 10'd10, 10'd900, 1'b1, 1'b0);
        send_item(10'd600, 10'd50, 10'd10, 10'd900, 1'b1, 1'b1);
        drain_and_settle();

        // register extremes: all low, all high, steepest negative slope
        set_config('0, '0, '0, '0, '0);
        repeat (15) send_random_item();
        drain_and_settle();
        set_config(10'd1023, 10'd1023, REF_SLOPE_W'(256000), 10'd1023, 12'd4095);
        repeat (15) send_random_item();
        drain_and_settle();
        set_config('0, 10'd1023, REF_SLOPE_W'(-256000), '0, '0);
        repeat (15) send_random_item();
        drain_and_settle();

        // random settings; in one phase the receiver holds off for a long
        // stretch while items keep being offered without gaps
        for (int p = 0; p < 5; p++) begin
            set_random_config();
            if (p == 2) begin
                tx_idle_on  = 1'b0;
                hold_serial = hold_serial + 1;
            end
            repeat (25) send_random_item();
            tx_idle_on = 1'b1;
            drain_and_settle();
        end

        // Last part, no idling from here on. First drive the top-left count
        // well past a minimum of 30, then check it is clear again.
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        set_config(RST_REF_X, RST_REF_Y, RST_REF_SLOPE, RST_BORDER_ROW, 12'd30);
        send_item('0, '0, '0, '0, 1'b0, 1'b1);
        repeat (FILL_SEGMENTS)
            send_item(COORD_W'($urandom_range(0, 318)), COORD_W'($urandom_range(0, 139)),
                      COORD_W'($urandom_range(0, 318)), COORD_W'($urandom_range(0, 139)),
                      1'b1, 1'b0);
        send_item('0, '0, '0, '0, 1'b0, 1'b1);
        send_item('0, '0, '0, '0, 1'b0, 1'b1);  // counts must be clear again
        drain_and_settle();

        set_random_config();
        repeat (40) send_random_item();
        drain_and_settle();

        if (sb.n_errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
